// ===== src/csem_pkg.sv =====
// shared types and constants for the counting semaphore table
// no dependencies; used by csem_alu and counting_semaphore_table
`default_nettype none

package csem_pkg;

    // default sizes, handed to the top level parameters
    localparam int SEM_SLOTS_DEF = 8;
    localparam int PROCESSES_DEF = 16;

    // fixed field widths
    localparam int FUNC_W = 2;
    localparam int SID_W  = 3;
    localparam int IVAL_W = 15;
    localparam int PID_W  = 4;
    localparam int CNT_W  = 16;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WAIT    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POST    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DESTROY = 2'd3;

    // count saturation bound
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'h7fff;

    // request to the shared increment / decrement unit
    typedef struct packed {
        logic [CNT_W-1:0] operand;
        logic             dec;
    } alu_req_t;

endpackage

`default_nettype wire

// ===== src/counting_semaphore_table.sv =====
// top level of the counting semaphore table: sequencer, slot state, wait queues
// depends on csem_pkg, csem_ram, csem_alu
//
//   request channel (in_valid / in_stall): one beat of func, sem_id, init_value,
//   caller_pid; func selects init, wait, post or destroy
//   result channel (out_valid / out_stall): status, slot_id, caller_blocked,
//   woken_valid, woken_pid, last; one beat per request, except destroy with
//   waiters, one beat per waiter, oldest first; last marks the final beat
//   one request at a time, in_stall high while busy; steps after accept:
//     wait, post without a waiter, empty destroy, error: exec loads the beat
//     post releasing a waiter: exec, then drain loads the beat
//     destroy with n waiters: exec, then drain loads the n beats, one per waiter
//     init: scan from slot 0 loads the beat at the lowest free slot, or the
//     error beat at SEM_SLOTS - 1 when full; one in-use bit scanned per cycle
//   the slot ram read is registered: exec works on the record looked up in idle
//   reset: all slots free, all queues empty, no result pending; no clearing
//   pass, no queue ram word is used before it is written
//   receiver stall: the pending beat holds in the output register; the next
//   request may still be accepted, and the sequencer waits before emitting
//   the beat after it
`default_nettype none

module counting_semaphore_table #(
    parameter int SEM_SLOTS = csem_pkg::SEM_SLOTS_DEF,
    parameter int PROCESSES = csem_pkg::PROCESSES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [csem_pkg::FUNC_W-1:0]   func,
    input  wire logic [csem_pkg::SID_W-1:0]    sem_id,
    input  wire logic [csem_pkg::IVAL_W-1:0]   init_value,
    input  wire logic [csem_pkg::PID_W-1:0]    caller_pid,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               status,
    output logic      [csem_pkg::SID_W-1:0]    slot_id,
    output logic                               caller_blocked,
    output logic                               woken_valid,
    output logic      [csem_pkg::PID_W-1:0]    woken_pid,
    output logic                               last
);

    // slot index, queue position, queue fill and queue ram address widths
    localparam int SW = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
    localparam int PW = $clog2(PROCESSES);
    localparam int CW = $clog2(PROCESSES + 1);
    localparam int QDEPTH = SEM_SLOTS * PROCESSES;
    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // per-slot record kept in the slot ram
    typedef struct packed {
        logic [csem_pkg::CNT_W-1:0] count;
        logic [PW-1:0]              head;
        logic [PW-1:0]              tail;
        logic [CW-1:0]              fcnt;
    } slot_rec_t;

    localparam int RW = $bits(slot_rec_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_DRAIN
    } state_t;

    // ring position advance
    function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (p == PW'(PROCESSES - 1)) ? '0 : p + PW'(1);
        return r;
    endfunction

    // queue ram address of a slot's ring position
    function automatic logic [AW-1:0] q_addr(input logic [SW-1:0] s,
                                             input logic [PW-1:0] p);
        logic [AW-1:0] a;
        a = AW'(s) * AW'(PROCESSES) + AW'(p);
        return a;
    endfunction

    // sequencer and request registers
    state_t                        state_reg,   state_next;
    logic [csem_pkg::FUNC_W-1:0]   func_reg,    func_next;
    logic [csem_pkg::SID_W-1:0]    sid_reg,     sid_next;
    logic                          sid_ok_reg,  sid_ok_next;
    logic [csem_pkg::IVAL_W-1:0]   ival_reg,    ival_next;
    logic [csem_pkg::PID_W-1:0]    pid_reg,     pid_next;
    logic [SW-1:0]                 idx_reg,     idx_next;
    logic [PW-1:0]                 head_reg,    head_next;
    logic [CW-1:0]                 left_reg,    left_next;
    logic [SEM_SLOTS-1:0]          in_use_reg,  in_use_next;

    // result register
    logic                          out_valid_reg,   out_valid_next;
    logic                          status_reg,      status_next;
    logic [csem_pkg::SID_W-1:0]    slot_id_reg,     slot_id_next;
    logic                          blocked_reg,     blocked_next;
    logic                          woken_valid_reg, woken_valid_next;
    logic [csem_pkg::PID_W-1:0]    woken_pid_reg,   woken_pid_next;
    logic                          last_reg,        last_next;

    // ram ports
    logic                          slot_wr_en;
    slot_rec_t                     slot_wr_data;
    slot_rec_t                     slot_rd_data;
    logic [SW-1:0]                 slot_rd_addr;
    logic                          q_wr_en;
    logic [AW-1:0]                 q_wr_addr;
    logic [AW-1:0]                 q_rd_addr;
    logic [csem_pkg::PID_W-1:0]    q_rd_data;

    // shared unit
    csem_pkg::alu_req_t            alu_req;
    logic [csem_pkg::CNT_W-1:0]    alu_sum;

    logic accept;
    logic out_free;
    logic slot_live;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    // a result beat may be loaded when the output register is empty or draining
    assign out_free = !out_valid_reg || !out_stall;
    assign slot_live = sid_ok_reg && in_use_reg[idx_reg];

    // during idle the slot ram looks up the incoming request's slot
    assign slot_rd_addr = (state_reg == ST_IDLE) ? SW'(sem_id) : idx_reg;

    csem_ram #(
        .WIDTH (RW),
        .DEPTH (SEM_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (idx_reg),
        .wr_data (slot_wr_data),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    csem_ram #(
        .WIDTH (csem_pkg::PID_W),
        .DEPTH (QDEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (q_wr_addr),
        .wr_data (pid_reg),
        .rd_addr (q_rd_addr),
        .rd_data (q_rd_data)
    );

    csem_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    // shared unit: scan index step during init, count step otherwise
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            alu_req.operand = csem_pkg::CNT_W'(idx_reg);
            alu_req.dec     = 1'b0;
        end
        else
        begin
            alu_req.operand = slot_rd_data.count;
            alu_req.dec     = (func_reg == csem_pkg::FUNC_WAIT);
        end
    end

    // queue read: the head of the record during exec, the drain pointer after
    always_comb
    begin
        if (state_reg == ST_DRAIN)
        begin
            q_rd_addr = q_addr(idx_reg, out_free ? next_pos(head_reg) : head_reg);
        end
        else
        begin
            q_rd_addr = q_addr(idx_reg, slot_rd_data.head);
        end
    end

    assign q_wr_addr = q_addr(idx_reg, slot_rd_data.tail);

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        sid_next         = sid_reg;
        sid_ok_next      = sid_ok_reg;
        ival_next        = ival_reg;
        pid_next         = pid_reg;
        idx_next         = idx_reg;
        head_next        = head_reg;
        left_next        = left_reg;
        in_use_next      = in_use_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        slot_id_next     = slot_id_reg;
        blocked_next     = blocked_reg;
        woken_valid_next = woken_valid_reg;
        woken_pid_next   = woken_pid_reg;
        last_next        = last_reg;
        slot_wr_en       = 1'b0;
        slot_wr_data     = slot_rd_data;
        q_wr_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next   = func;
                    sid_next    = sem_id;
                    sid_ok_next = ({29'b0, sem_id} < 32'(SEM_SLOTS));
                    ival_next   = init_value;
                    pid_next    = caller_pid;
                    if (func == csem_pkg::FUNC_INIT)
                    begin
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        idx_next   = SW'(sem_id);
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_SCAN:
            begin
                // one in-use bit per cycle, lowest first
                if (!in_use_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        slot_wr_en           = 1'b1;
                        slot_wr_data.count   = csem_pkg::CNT_W'(ival_reg);
                        slot_wr_data.head    = '0;
                        slot_wr_data.tail    = '0;
                        slot_wr_data.fcnt    = '0;
                        in_use_next[idx_reg] = 1'b1;
                        out_valid_next       = 1'b1;
                        status_next          = 1'b0;
                        slot_id_next         = csem_pkg::SID_W'(idx_reg);
                        blocked_next         = 1'b0;
                        woken_valid_next     = 1'b0;
                        woken_pid_next       = '0;
                        last_next            = 1'b1;
                        state_next           = ST_IDLE;
                    end
                end
                else if (idx_reg == SW'(SEM_SLOTS - 1))
                begin
                    // table full
                    if (out_free)
                    begin
                        out_valid_next   = 1'b1;
                        status_next      = 1'b1;
                        slot_id_next     = '0;
                        blocked_next     = 1'b0;
                        woken_valid_next = 1'b0;
                        woken_pid_next   = '0;
                        last_next        = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next = SW'(alu_sum);
                end
            end

            ST_EXEC:
            begin
                if (out_free)
                begin
                    // default beat: ok, echo the slot, nothing else
                    status_next      = 1'b0;
                    slot_id_next     = sid_reg;
                    blocked_next     = 1'b0;
                    woken_valid_next = 1'b0;
                    woken_pid_next   = '0;
                    last_next        = 1'b1;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;

                    if (!slot_live)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        case (func_reg)
                            csem_pkg::FUNC_WAIT:
                            begin
                                if (alu_sum[csem_pkg::CNT_W-1])
                                begin
                                    if (slot_rd_data.fcnt == CW'(PROCESSES))
                                    begin
                                        // queue full
                                        status_next = 1'b1;
                                    end
                                    else
                                    begin
                                        q_wr_en            = 1'b1;
                                        slot_wr_en         = 1'b1;
                                        slot_wr_data.count = alu_sum;
                                        slot_wr_data.tail  = next_pos(slot_rd_data.tail);
                                        slot_wr_data.fcnt  = slot_rd_data.fcnt + CW'(1);
                                        blocked_next       = 1'b1;
                                    end
                                end
                                else
                                begin
                                    slot_wr_en         = 1'b1;
                                    slot_wr_data.count = alu_sum;
                                end
                            end

                            csem_pkg::FUNC_POST:
                            begin
                                slot_wr_en = 1'b1;
                                if (slot_rd_data.count != csem_pkg::COUNT_MAX)
                                begin
                                    slot_wr_data.count = alu_sum;
                                end
                                if (slot_rd_data.count[csem_pkg::CNT_W-1] &&
                                    (slot_rd_data.fcnt != '0))
                                begin
                                    // release the oldest waiter in drain
                                    slot_wr_data.head = next_pos(slot_rd_data.head);
                                    slot_wr_data.fcnt = slot_rd_data.fcnt - CW'(1);
                                    head_next         = slot_rd_data.head;
                                    left_next         = CW'(1);
                                    out_valid_next    = out_valid_reg && out_stall;
                                    state_next        = ST_DRAIN;
                                end
                            end

                            csem_pkg::FUNC_DESTROY:
                            begin
                                if (slot_rd_data.fcnt == '0)
                                begin
                                    in_use_next[idx_reg] = 1'b0;
                                end
                                else
                                begin
                                    head_next      = slot_rd_data.head;
                                    left_next      = slot_rd_data.fcnt;
                                    out_valid_next = out_valid_reg && out_stall;
                                    state_next     = ST_DRAIN;
                                end
                            end

                            default:
                            begin
                                status_next = 1'b1;
                            end
                        endcase
                    end
                end
            end

            ST_DRAIN:
            begin
                // one released waiter per beat
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = 1'b0;
                    slot_id_next     = sid_reg;
                    blocked_next     = 1'b0;
                    woken_valid_next = 1'b1;
                    woken_pid_next   = q_rd_data;
                    last_next        = (left_reg == CW'(1));
                    head_next        = next_pos(head_reg);
                    left_next        = left_reg - CW'(1);
                    if (left_reg == CW'(1))
                    begin
                        if (func_reg == csem_pkg::FUNC_DESTROY)
                        begin
                            in_use_next[idx_reg] = 1'b0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            func_reg        <= csem_pkg::FUNC_INIT;
            sid_reg         <= '0;
            sid_ok_reg      <= 1'b0;
            ival_reg        <= '0;
            pid_reg         <= '0;
            idx_reg         <= '0;
            head_reg        <= '0;
            left_reg        <= '0;
            in_use_reg      <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= 1'b0;
            slot_id_reg     <= '0;
            blocked_reg     <= 1'b0;
            woken_valid_reg <= 1'b0;
            woken_pid_reg   <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            func_reg        <= func_next;
            sid_reg         <= sid_next;
            sid_ok_reg      <= sid_ok_next;
            ival_reg        <= ival_next;
            pid_reg         <= pid_next;
            idx_reg         <= idx_next;
            head_reg        <= head_next;
            left_reg        <= left_next;
            in_use_reg      <= in_use_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            slot_id_reg     <= slot_id_next;
            blocked_reg     <= blocked_next;
            woken_valid_reg <= woken_valid_next;
            woken_pid_reg   <= woken_pid_next;
            last_reg        <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign slot_id        = slot_id_reg;
    assign caller_blocked = blocked_reg;
    assign woken_valid    = woken_valid_reg;
    assign woken_pid      = woken_pid_reg;
    assign last           = last_reg;

    // a drain never runs with nothing left to release
    ap_drain_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (left_reg != '0))
        else $error("drain entered with empty waiter count");

    // once the sequencer is back in idle, the pending beat closes its request
    ap_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (state_reg == ST_IDLE)) |-> last_reg)
        else $error("request finished without a last beat");

    // an error beat is single and carries no queue activity
    ap_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (!woken_valid_reg && !blocked_reg && last_reg))
        else $error("error beat with queue activity");

    // slot ownership only changes when a request completes
    ap_idle_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> $stable(in_use_reg))
        else $error("in-use bits changed while idle");

endmodule

`default_nettype wire

// ===== src/csem_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module csem_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/csem_alu.sv =====
// shared increment / decrement unit for counts and scan indexes
// depends on csem_pkg
`default_nettype none

module csem_alu (
    input  wire csem_pkg::alu_req_t               req,
    output logic      [csem_pkg::CNT_W-1:0]       sum
);

    // one adder: add all-ones to decrement, one to increment
    assign sum = req.operand + (req.dec ? {csem_pkg::CNT_W{1'b1}}
                                        : csem_pkg::CNT_W'(1));

endmodule

`default_nettype wire
